// File: rtl/brib_pkg.sv
package brib_pkg;

  localparam int WordW    = 32;
  localparam int ByteW    = 8;
  localparam int ByteCntW = $clog2(WordW / ByteW);
  localparam int DivCntW  = $clog2(WordW);

  typedef enum logic [0:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_PREP  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } brib_state_t;

  typedef struct packed {
    logic take_byte;
    logic setup;
    logic prep;
    logic div_step;
    logic emit;
  } brib_cmd_t;

  typedef struct packed {
    logic word_done;
    logic div_done;
    logic reject;
    logic out_free;
  } brib_status_t;

endpackage

// File: rtl/brib_if.sv
interface brib_byte_if;
  logic                        valid;
  logic                        ready;
  logic [brib_pkg::ByteW-1:0]  random_byte;

  modport source (output valid, output random_byte, input ready);
  modport sink (input valid, input random_byte, output ready);
endinterface

interface brib_value_if;
  logic                              valid;
  logic                              ready;
  logic signed [brib_pkg::WordW-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// File: rtl/brib_ctrl.sv
module brib_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  brib_pkg::brib_status_t st,
  output brib_pkg::brib_cmd_t    cmd
);
  import brib_pkg::*;

  brib_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.take_byte = in_valid;
        if (in_valid && st.word_done) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.reject) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/brib_dp.sv
module brib_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  brib_pkg::brib_cmd_t                 cmd,
  output brib_pkg::brib_status_t              st,
  input  logic [brib_pkg::ByteW-1:0]          random_byte,
  input  logic                                cfg_we,
  input  brib_pkg::cfg_reg_t                  cfg_index,
  input  logic [brib_pkg::WordW-1:0]          cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [brib_pkg::WordW-1:0]   random_value
);
  import brib_pkg::*;

  logic [WordW-1:0]    range_low_r, range_high_r;
  logic [ByteCntW-1:0] byte_cnt_r;
  logic [DivCntW-1:0]  div_cnt_r;
  logic                out_valid_r;
  logic [WordW-1:0]    out_value_r;

  logic [WordW-1:0]    word_r;
  logic [WordW-1:0]    lo_r;
  logic [WordW-1:0]    span_r;
  logic [WordW-1:0]    div_r;
  logic                full_r;
  logic [WordW-1:0]    rem_r, rem_nxt;

  logic                swap;
  logic [WordW:0]      trial;
  logic [WordW:0]      trial_diff;
  logic [WordW-1:0]    base;
  logic [WordW-1:0]    result;

  assign swap = $signed(range_high_r) < $signed(range_low_r);

  assign trial      = {rem_r, word_r[~div_cnt_r]};
  assign trial_diff = trial - {1'b0, div_r};
  assign rem_nxt    = trial_diff[WordW] ? trial[WordW-1:0] : trial_diff[WordW-1:0];

  assign base   = word_r - rem_r;
  assign result = lo_r + (full_r ? word_r : rem_r);

  always_comb begin
    st.word_done = &byte_cnt_r;
    st.div_done  = &div_cnt_r;
    st.reject    = !full_r && (base > ~div_r);
    st.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
      byte_cnt_r   <= '0;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RANGE_LOW:  range_low_r  <= cfg_wdata;
          REG_RANGE_HIGH: range_high_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.take_byte) begin
        byte_cnt_r <= byte_cnt_r + 1'b1;
      end
      if (cmd.prep) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      word_r[byte_cnt_r*ByteW +: ByteW] <= random_byte;
    end
    if (cmd.setup) begin
      lo_r   <= swap ? range_high_r : range_low_r;
      span_r <= swap ? (range_low_r - range_high_r) : (range_high_r - range_low_r);
    end
    if (cmd.prep) begin
      div_r  <= span_r + 1'b1;
      full_r <= &span_r;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
    end
    if (cmd.emit) begin
      out_value_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign random_value = $signed(out_value_r);

endmodule

// File: rtl/bounded_random_int_from_bytes.sv
// Draws uniform signed integers in the inclusive range set by range_low and range_high
// (swapped internally if given reversed) from a stream of random bytes. Four accepted
// bytes, least significant first, form one 32-bit word; bytes one to three are taken at
// one per cycle. The fourth byte starts the setup steps S_SETUP and S_PREP, then a
// bit-serial remainder unit over all 32 word bits, then a step that checks and loads the
// result; no byte of the next word is taken before that step is done. Words that would
// bias the result are dropped without output. One result waits in the output register;
// the next word is taken and reduced while it waits, and the block then holds an accepted
// word at the check step, with the input stalled, until the output register frees.
module bounded_random_int_from_bytes (
  input  logic                          clk,
  input  logic                          rst_n,
  brib_byte_if.sink                     in_byte,
  brib_value_if.source                  out_value,
  input  logic                          cfg_we,
  input  brib_pkg::cfg_reg_t            cfg_index,
  input  logic [brib_pkg::WordW-1:0]    cfg_wdata
);
  import brib_pkg::*;

  brib_cmd_t    cmd;
  brib_status_t st;

  brib_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_byte.valid),
    .in_ready (in_byte.ready),
    .st       (st),
    .cmd      (cmd)
  );

  brib_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .random_byte  (in_byte.random_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_value.valid),
    .out_ready    (out_value.ready),
    .random_value (out_value.random_value)
  );

endmodule

// File: rtl/brib_checker.sv
module brib_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [brib_pkg::WordW-1:0] out_value,
  input  logic                              cfg_we,
  input  brib_pkg::cfg_reg_t                cfg_index,
  input  logic [brib_pkg::WordW-1:0]        cfg_wdata
);
  import brib_pkg::*;

  logic signed [WordW-1:0] bound_a_r, bound_b_r;
  logic signed [WordW-1:0] bound_min, bound_max;
  logic [ByteCntW-1:0]     beat_cnt_r;
  logic                    in_beat;

  assign in_beat   = in_valid && in_ready;
  assign bound_min = (bound_a_r < bound_b_r) ? bound_a_r : bound_b_r;
  assign bound_max = (bound_a_r < bound_b_r) ? bound_b_r : bound_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_a_r  <= '0;
      bound_b_r  <= '0;
      beat_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RANGE_LOW:  bound_a_r <= $signed(cfg_wdata);
          REG_RANGE_HIGH: bound_b_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (in_beat) begin
        beat_cnt_r <= beat_cnt_r + 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result beat dropped or changed while stalled");

  a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (&beat_cnt_r) |=> !in_ready)
    else $error("input taken right after the last byte of a word");

  a_load_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a word being processed");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value >= bound_min) && (out_value <= bound_max))
    else $error("result outside configured range");

endmodule

bind bounded_random_int_from_bytes brib_checker u_brib_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_byte.valid),
  .in_ready  (in_byte.ready),
  .out_valid (out_value.valid),
  .out_ready (out_value.ready),
  .out_value (out_value.random_value),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

// File: verif/bounded_random_int_from_bytes_tb.sv
`timescale 1ns / 1ps

module bounded_random_int_from_bytes_tb;
  import brib_pkg::*;

  localparam int HalfPeriod    = 2;
  localparam int ResetCycles   = 5;
  localparam int DrainCycles   = 60;
  localparam int HoldOffCycles = 400;
  localparam int CycleLimit    = 600000;
  localparam int FixedPhases   = 10;
  localparam int PhaseCount    = 18;
  localparam int WordsPerPhase = 24;
  localparam logic [31:0] SignBit = 32'h8000_0000;

  typedef enum logic [1:0] {
    FROM_PREDICTOR,
    TYPED_VALUE,
    TYPED_NONE
  } check_kind_t;

  typedef struct packed {
    logic        is_write;
    cfg_reg_t    sel;
    logic [31:0] wdata;
    logic [7:0]  data;
    check_kind_t check;
    logic [31:0] value;
  } step_row_t;

  localparam int DirectedCount = 30;
  localparam step_row_t DirectedSteps [DirectedCount] = '{
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, TYPED_VALUE, 32'h0},
    // all-ones word is dropped when both bounds are equal
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, TYPED_NONE, 32'h0},
    // full 32-bit span: wrap low + word
    '{1'b1, REG_RANGE_LOW, 32'h8000_0000, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b1, REG_RANGE_HIGH, 32'h7FFF_FFFF, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h01, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, TYPED_VALUE, 32'h8000_0001},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'hFF, TYPED_VALUE, 32'h7FFF_FFFF},
    // reversed bounds
    '{1'b1, REG_RANGE_LOW, 32'd5, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b1, REG_RANGE_HIGH, 32'hFFFF_FFFD, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h0A, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h00, FROM_PREDICTOR, 32'h0},
    // bounds change in the middle of a word
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h11, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h22, FROM_PREDICTOR, 32'h0},
    '{1'b1, REG_RANGE_LOW, 32'd100, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b1, REG_RANGE_HIGH, 32'd100, 8'h00, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h33, FROM_PREDICTOR, 32'h0},
    '{1'b0, REG_RANGE_LOW, 32'h0, 8'h44, TYPED_VALUE, 32'd100}
  };

  localparam logic [31:0] FixedLow [FixedPhases] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hC000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_000A
  };
  localparam logic [31:0] FixedHigh [FixedPhases] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h0000_0001, 32'hFFFF_FFF6
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [WordW-1:0] cfg_wdata;

  brib_byte_if  byte_ch ();
  brib_value_if value_ch ();

  bounded_random_int_from_bytes dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (byte_ch.sink),
    .out_value (value_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [31:0] bound_reg [2] = '{32'h0, 32'h0};
  logic [1:0]  held_cnt = 2'd0;
  logic [23:0] held_bytes = 24'h0;
  logic [31:0] pending_values [$];

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  bit   steady_feed = 1'b0;
  logic hold_off_req = 1'b0;
  int   hold_count = 0;
  int   pattern_left = 0;
  logic [1:0] pattern_mode = 2'd0;

  always begin
    clk = 1'b0;
    #HalfPeriod;
    clk = 1'b1;
    #HalfPeriod;
  end

  function automatic void span_of(output logic [31:0] base, output logic [32:0] span);
    logic [31:0] top;
    if ($signed(bound_reg[REG_RANGE_LOW]) <= $signed(bound_reg[REG_RANGE_HIGH])) begin
      base = bound_reg[REG_RANGE_LOW];
      top  = bound_reg[REG_RANGE_HIGH];
    end else begin
      base = bound_reg[REG_RANGE_HIGH];
      top  = bound_reg[REG_RANGE_LOW];
    end
    span = {1'b0, top ^ SignBit} - {1'b0, base ^ SignBit} + 33'd1;
  endfunction

  // first word value that is dropped for this span
  function automatic logic [31:0] accept_limit(input logic [32:0] span);
    if (span[32]) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF - (32'hFFFF_FFFF % span[31:0]);
  endfunction

  task automatic absorb_byte(input logic [7:0] b, output logic got,
                             output logic [31:0] value);
    logic [31:0] word;
    logic [31:0] base;
    logic [32:0] span;
    got = 1'b0;
    value = '0;
    if (held_cnt != 2'd3) begin
      held_bytes[8*held_cnt +: 8] = b;
      held_cnt = held_cnt + 2'd1;
    end else begin
      word = {b, held_bytes};
      held_bytes = '0;
      held_cnt = 2'd0;
      span_of(base, span);
      if (span[32]) begin
        value = base + word;
        got = 1'b1;
      end else if (word < accept_limit(span)) begin
        value = base + (word % span[31:0]);
        got = 1'b1;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input check_kind_t check,
                           input logic [31:0] typed);
    logic        got;
    logic [31:0] value;
    byte_ch.valid <= 1'b1;
    byte_ch.random_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    absorb_byte(b, got, value);
    case (check)
      FROM_PREDICTOR: if (got) pending_values.push_back(value);
      TYPED_VALUE: pending_values.push_back(typed);
      default: ;
    endcase
  endtask

  task automatic pace();
    int gap;
    if (steady_feed) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_bound(input cfg_reg_t sel, input logic [31:0] data);
    byte_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    // a dropped word may still be in the divider
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    bound_reg[sel] = data;
  endtask

  always @(posedge clk) begin
    if (hold_off_req && hold_count < HoldOffCycles) begin
      value_ch.ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode <= 2'($urandom_range(0, 3));
        pattern_left <= $urandom_range(16, 96);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (pattern_mode)
        2'd0: value_ch.ready <= 1'b1;
        2'd1: value_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: value_ch.ready <= ($urandom_range(0, 7) == 0);
        default: value_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && value_ch.valid && value_ch.ready) begin
      if (pending_values.size() == 0) begin
        $display("%0t: random_value expected none, got %h", $time,
                 value_ch.random_value);
        mismatch_count++;
      end else begin
        if (pending_values[0] !== value_ch.random_value) begin
          $display("%0t: random_value expected %h, got %h", $time,
                   pending_values[0], value_ch.random_value);
          mismatch_count++;
        end
        void'(pending_values.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] base;
    logic [31:0] word;
    logic [31:0] limit_word;
    logic [32:0] span;
    rst_n <= 1'b0;
    byte_ch.valid <= 1'b0;
    byte_ch.random_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RANGE_LOW;
    cfg_wdata <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedSteps[i]) begin
      if (DirectedSteps[i].is_write) begin
        write_bound(DirectedSteps[i].sel, DirectedSteps[i].wdata);
      end else begin
        send_byte(DirectedSteps[i].data, DirectedSteps[i].check, DirectedSteps[i].value);
      end
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase < FixedPhases) begin
        lo = FixedLow[phase];
        hi = FixedHigh[phase];
      end else begin
        lo = $urandom;
        case ($urandom_range(0, 2))
          0: hi = $urandom;
          1: hi = lo + $urandom_range(0, 1000);
          default: hi = lo + ($urandom >> $urandom_range(0, 31));
        endcase
      end
      write_bound(REG_RANGE_LOW, lo);
      write_bound(REG_RANGE_HIGH, hi);
      // fill the output and stall the input while bytes keep coming
      if (phase == 0) begin
        hold_off_req <= 1'b1;
        steady_feed = 1'b1;
      end
      span_of(base, span);
      limit_word = accept_limit(span);
      while (held_cnt != 2'd0) begin
        send_byte(8'($urandom_range(0, 255)), FROM_PREDICTOR, '0);
        pace();
      end
      repeat (WordsPerPhase) begin
        case ($urandom_range(0, 9))
          0: word = limit_word - 32'd1;
          1: word = limit_word;
          2: word = 32'hFFFF_FFFF;
          3: word = 32'h0;
          4: word = limit_word + 32'($urandom_range(0, 3));
          default: word = $urandom;
        endcase
        for (int k = 0; k < 4; k++) begin
          send_byte(word[8*k +: 8], FROM_PREDICTOR, '0);
          pace();
        end
      end
      steady_feed = 1'b0;
      // may leave part of a word pending across the next bound change
      repeat ($urandom_range(0, 3)) begin
        send_byte(8'($urandom_range(0, 255)), FROM_PREDICTOR, '0);
        pace();
      end
    end

    byte_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
